// ===== sv/channel_average_accumulator_macros.svh =====
// Assertion helpers shared by the accumulator RTL.
// Each macro expects clk and rst_n in scope.
`ifndef CHANNEL_AVERAGE_ACCUMULATOR_MACROS_SVH
`define CHANNEL_AVERAGE_ACCUMULATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define CAVG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CAVG_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CAVG_ASSERT(lbl, prop, msg)
`define CAVG_NEVER(lbl, cond, msg)
`endif
`endif

// ===== sv/cavg_pkg.sv =====
`default_nettype none
package cavg_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int COUNT_BITS   = 32;

  localparam int CH_W   = 3;
  localparam int SMP_W  = 15;
  localparam int AVG_W  = 15;
  // sum of up to 2^COUNT_BITS-1 samples
  localparam int SUM_W  = COUNT_BITS + SMP_W;
  localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int STEP_W = $clog2(AVG_W + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(NUM_CHANNELS - 1);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic [SUM_W-1:0]      sum;
    logic [COUNT_BITS-1:0] cnt;
    logic [SMP_W-1:0]      latest;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

endpackage
`default_nettype wire

// ===== sv/channel_average_accumulator.sv =====
`default_nettype none
// Per-channel accumulate and average.
// Command port: a word is taken at a rising edge with start high and busy low.
//   in_command = sample: in_sample is added to channel in_channel's sum, its
//   count goes up by one (saturating; a saturated channel keeps sum and count)
//   and the sample becomes the channel's latest value. No result. Samples on
//   channels beyond the configured count are dropped.
//   in_command = read: one result per channel, channel 0 first, each shown for
//   one cycle with out_valid high; out_last marks the final channel. Sums and
//   counts are cleared as they are read, latest values stay.
// Throughput: samples go one per cycle while no read runs; busy stays low
//   between them. The state sits in one 8-entry memory with a registered
//   read, updated read-modify-write, and the write of the previous sample is
//   forwarded into the next one. Read sequence: per channel memory read and
//   load; an empty channel then gives its result, any other first runs 15
//   steps of the restoring divider; busy is high for the whole read.
// Reset (rst_n low, synchronous) clears all sums, counts and latest values.
// Results cannot be held off; each is valid for its single strobe cycle.
`include "channel_average_accumulator_macros.svh"
module channel_average_accumulator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_command,
  input  wire logic [cavg_pkg::CH_W-1:0]  in_channel,
  input  wire logic [cavg_pkg::SMP_W-1:0] in_sample,
  output logic                            out_valid,
  output logic [cavg_pkg::CH_W-1:0]       out_channel,
  output logic [cavg_pkg::AVG_W-1:0]      out_average,
  output logic [cavg_pkg::SMP_W-1:0]      out_latest,
  output logic                            out_empty_res,
  output logic                            out_last
);
  import cavg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_DIV  = 4'b1000
  } state_t;

  state_t st_r, st_nxt;
  logic [IDX_W-1:0] ch_r, ch_nxt;
  logic [SMP_W-1:0] lat_r;

  logic accept;
  logic smp_acc;

  // sample pipeline
  logic             s1_vld_r;
  logic [IDX_W-1:0] s1_ch_r;
  logic [SMP_W-1:0] s1_smp_r;
  logic             wb_vld_r;
  logic [IDX_W-1:0] wb_ch_r;
  entry_t           wb_data_r;
  entry_t           old_ent;
  entry_t           upd_ent;

  req_t    rd_req;
  req_t    clr_req;
  wr_req_t wr_req;
  entry_t  rd_data;

  logic             div_start;
  logic             div_done;
  logic [AVG_W-1:0] div_quo;

  logic             emit;
  logic [AVG_W-1:0] emit_avg;
  logic             emit_empty;

  logic             out_valid_r;
  logic             out_last_r;
  logic [CH_W-1:0]  out_ch_r;
  logic [AVG_W-1:0] out_avg_r;
  logic [SMP_W-1:0] out_lat_r;
  logic             out_empty_r;

  assign busy    = (st_r != ST_IDLE);
  assign accept  = start && !busy;
  assign smp_acc = accept && (in_command == CMD_SAMPLE) &&
                   (32'(in_channel) < NUM_CHANNELS);

  cavg_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (rd_req),
    .wr      (wr_req),
    .clr     (clr_req),
    .rd_data (rd_data)
  );

  cavg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data.sum),
    .divisor  (rd_data.cnt),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    rd_req.en    = smp_acc || (st_r == ST_RD);
    rd_req.addr  = (st_r == ST_RD) ? ch_r : IDX_W'(in_channel);
    clr_req.en   = (st_r == ST_LOAD);
    clr_req.addr = ch_r;
  end

  // the memory misses the write made at the edge of the read
  always_comb begin
    old_ent = (wb_vld_r && (wb_ch_r == s1_ch_r)) ? wb_data_r : rd_data;
    upd_ent = old_ent;
    upd_ent.latest = s1_smp_r;
    if (old_ent.cnt != COUNT_MAX) begin
      upd_ent.sum = old_ent.sum + SUM_W'(s1_smp_r);
      upd_ent.cnt = old_ent.cnt + 1'b1;
    end
    wr_req.en   = s1_vld_r;
    wr_req.addr = s1_ch_r;
    wr_req.data = upd_ent;
  end

  always_ff @(posedge clk) begin
    if (smp_acc) begin
      s1_ch_r  <= IDX_W'(in_channel);
      s1_smp_r <= in_sample;
    end
    if (s1_vld_r) begin
      wb_ch_r   <= s1_ch_r;
      wb_data_r <= upd_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      wb_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= smp_acc;
      wb_vld_r <= s1_vld_r;
    end
  end

  // read sequencer
  always_comb begin
    st_nxt     = st_r;
    ch_nxt     = ch_r;
    emit       = 1'b0;
    emit_avg   = '0;
    emit_empty = 1'b0;
    div_start  = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (accept && (in_command == CMD_READ)) begin
          ch_nxt = '0;
          st_nxt = ST_RD;
        end
      end
      ST_RD: begin
        st_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (rd_data.cnt == '0) begin
          emit       = 1'b1;
          emit_empty = 1'b1;
        end else begin
          div_start = 1'b1;
          st_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          emit     = 1'b1;
          emit_avg = div_quo;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    if (emit) begin
      if (ch_r == LAST_IDX) begin
        st_nxt = ST_IDLE;
      end else begin
        ch_nxt = ch_r + 1'b1;
        st_nxt = ST_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= emit;
      out_last_r  <= emit && (ch_r == LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_LOAD) begin
      lat_r <= rd_data.latest;
    end
    if (emit) begin
      out_ch_r    <= CH_W'(ch_r);
      out_avg_r   <= emit_avg;
      out_lat_r   <= (st_r == ST_LOAD) ? rd_data.latest : lat_r;
      out_empty_r <= emit_empty;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_last      = out_last_r;
  assign out_channel   = out_ch_r;
  assign out_average   = out_avg_r;
  assign out_latest    = out_lat_r;
  assign out_empty_res = out_empty_r;

  `CAVG_ASSERT(a_out_from_read, out_valid_r |-> $past(st_r != ST_IDLE), "result outside a read")
  `CAVG_ASSERT(a_last_strobed, out_last_r |-> out_valid_r, "last mark without a result")
  `CAVG_ASSERT(a_read_goes_busy, (accept && (in_command == CMD_READ)) |=> busy, "read not busy")
  `CAVG_ASSERT(a_update_idle, s1_vld_r |-> (st_r == ST_IDLE), "sample update during a read")
  `CAVG_NEVER(a_div_stray, div_done && (st_r != ST_DIV), "divider result outside divide state")

endmodule
`default_nettype wire

// ===== sv/cavg_store.sv =====
`default_nettype none
`include "channel_average_accumulator_macros.svh"
module cavg_store (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cavg_pkg::req_t   rd,
  input  wire cavg_pkg::wr_req_t wr,
  input  wire cavg_pkg::req_t   clr,
  output cavg_pkg::entry_t      rd_data
);
  import cavg_pkg::*;

  entry_t                  mem [NUM_CHANNELS];
  entry_t                  rd_q_r;
  logic [NUM_CHANNELS-1:0] acc_vld_r;
  logic [NUM_CHANNELS-1:0] lat_vld_r;
  logic                    rd_acc_v_r;
  logic                    rd_lat_v_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_q_r <= mem[rd.addr];
    end
  end

  // invalid sum/count and latest read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r  <= '0;
      lat_vld_r  <= '0;
      rd_acc_v_r <= 1'b0;
      rd_lat_v_r <= 1'b0;
    end else begin
      if (rd.en) begin
        rd_acc_v_r <= acc_vld_r[rd.addr];
        rd_lat_v_r <= lat_vld_r[rd.addr];
      end
      if (wr.en) begin
        acc_vld_r[wr.addr] <= 1'b1;
        lat_vld_r[wr.addr] <= 1'b1;
      end
      if (clr.en) begin
        acc_vld_r[clr.addr] <= 1'b0;
      end
    end
  end

  always_comb begin
    rd_data.sum    = rd_acc_v_r ? rd_q_r.sum : '0;
    rd_data.cnt    = rd_acc_v_r ? rd_q_r.cnt : '0;
    rd_data.latest = rd_lat_v_r ? rd_q_r.latest : '0;
  end

  `CAVG_NEVER(a_wr_clr_overlap, wr.en && clr.en, "write and clear in the same cycle")

endmodule
`default_nettype wire

// ===== sv/cavg_div.sv =====
`default_nettype none
`include "channel_average_accumulator_macros.svh"
module cavg_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [cavg_pkg::SUM_W-1:0]     dividend,
  input  wire logic [cavg_pkg::COUNT_BITS-1:0] divisor,
  output logic                                done,
  output logic [cavg_pkg::AVG_W-1:0]          quotient
);
  import cavg_pkg::*;

  logic                  run_r;
  logic                  done_r;
  logic [STEP_W-1:0]     step_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [COUNT_BITS-1:0] rem_nxt;
  logic [COUNT_BITS-1:0] den_r;
  logic [AVG_W-1:0]      dvd_r;
  logic [AVG_W-1:0]      quo_r;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;

  // quotient fits AVG_W bits, so the top part of the dividend is already
  // below the divisor and only AVG_W restoring steps remain
  always_comb begin
    trial   = {rem_r, dvd_r[AVG_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[SUM_W-1:AVG_W];
      dvd_r <= dividend[AVG_W-1:0];
      den_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_r << 1;
      quo_r <= {quo_r[AVG_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= STEP_W'(AVG_W);
      end else if (run_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  `CAVG_NEVER(a_restart_busy, start && run_r, "divider restarted while running")
  `CAVG_ASSERT(a_done_after_run, done_r |-> $past(run_r), "done without a running division")

endmodule
`default_nettype wire
